/* hdl/sude_pkg.sv */
`default_nettype none

package sude_pkg;

    // Input opcodes.
    localparam logic [1:0] OP_WRITE   = 2'd0;
    localparam logic [1:0] OP_READ    = 2'd1;
    localparam logic [1:0] OP_RX      = 2'd2;
    localparam logic [1:0] OP_TIMEOUT = 2'd3;

    // Reply status codes.
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_TIMEOUT  = 2'd1;
    localparam logic [1:0] ST_BAD_HDR  = 2'd2;
    localparam logic [1:0] ST_CRC_FAIL = 2'd3;

    // Datagram constants.
    localparam logic [7:0] SYNC_BYTE   = 8'h05;
    localparam logic [7:0] MASTER_ADDR = 8'hFF;
    localparam logic [7:0] WRITE_FLAG  = 8'h80;
    localparam logic [7:0] CRC_POLY    = 8'h07;
    localparam logic [3:0] WRITE_LEN   = 4'd8;
    localparam logic [3:0] READ_LEN    = 4'd4;

    // Kind of work handed from the front to the back.
    typedef enum logic [1:0] {
        JOB_WRITE,
        JOB_READ,
        JOB_REPLY
    } job_kind_t;

    // One queued job. For a reply job, value carries the read value.
    typedef struct packed {
        job_kind_t   kind;
        logic [7:0]  node;
        logic [6:0]  reg_addr;
        logic [31:0] value;
        logic [1:0]  status;
        logic [15:0] error_count;
        logic        echo;
    } job_t;

    // Handoff from the front into the queue.
    typedef struct packed {
        logic push;
        job_t job;
    } job_push_t;

    // CRC8, polynomial 0x07, byte fed LSB first.
    function automatic logic [7:0] crc_feed(input logic [7:0] crc_in, input logic [7:0] b);
        logic [7:0] c;
        c = crc_in;
        for (int j = 0; j < 8; j++)
        begin
            if (c[7] ^ b[j])
            begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

/* hdl/sude_cmd_if.sv */
`default_nettype none

// Input channel: one word is one request, received byte or timeout tick.
interface sude_cmd_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [7:0]  node;
    logic [6:0]  reg_req;
    logic [31:0] value;
    logic [7:0]  rx_byte;

    modport source (output valid, opcode, node, reg_req, value, rx_byte, input ready);
    modport sink   (input valid, opcode, node, reg_req, value, rx_byte, output ready);
endinterface

`default_nettype wire

/* hdl/sude_rsp_if.sv */
`default_nettype none

// Output channel: one word is one datagram byte or one reply report.
interface sude_rsp_if;
    logic        valid;
    logic        ready;
    logic [7:0]  tx_byte;
    logic        tx_valid;
    logic        last;
    logic        reply_valid;
    logic [1:0]  status;
    logic [31:0] read_value;
    logic [15:0] error_count;
    logic        echo_seen;

    modport source (output valid, tx_byte, tx_valid, last, reply_valid, status,
                    read_value, error_count, echo_seen, input ready);
    modport sink   (input valid, tx_byte, tx_valid, last, reply_valid, status,
                    read_value, error_count, echo_seen, output ready);
endinterface

`default_nettype wire

/* hdl/stepper_uart_datagram_engine_unit.sv */
`default_nettype none

// Master engine for a single-wire stepper driver UART. Each input word is a
// write request, a read request, a received line byte or a timeout tick; the
// front takes one word per clock while its job queue has room, tracks the
// echo and reply phases, checks replies (sync, master address, register,
// CRC8) and keeps the saturating error count. The back turns each job into
// output words at one word per clock while the output is ready: a write gives
// 8 datagram bytes, a read gives 4, and a finished or timed-out read gives one
// reply report. The serializer in the back sets the sustained rate. A job
// passes through a queue entry and the output word register before its first
// word appears. No clearing pass is needed after reset.
module stepper_uart_datagram_engine_unit #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic clk,
    input  wire logic rst_n,
    sude_cmd_if.sink  cmd,
    sude_rsp_if.source rsp
);

    sude_pkg::job_push_t q_in;
    sude_pkg::job_t      head;
    logic                q_full;
    logic                head_valid;
    logic                pop;

    sude_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .q_full (q_full),
        .q_in   (q_in)
    );

    sude_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_in       (q_in),
        .full       (q_full),
        .head       (head),
        .head_valid (head_valid),
        .pop        (pop)
    );

    sude_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .head_valid (head_valid),
        .pop        (pop),
        .rsp        (rsp)
    );

endmodule

`default_nettype wire

/* hdl/sude_front.sv */
`default_nettype none

// Link state machine: tracks echo and reply phases, checks replies and
// queues one job per word that produces output.
module sude_front (
    input  wire logic           clk,
    input  wire logic           rst_n,
    sude_cmd_if.sink            cmd,
    input  wire logic           q_full,
    output sude_pkg::job_push_t q_in
);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_ECHO_WR,
        PH_ECHO_RD,
        PH_REPLY
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [3:0]  echo_left_reg, echo_left_next;
    logic [2:0]  reply_index_reg, reply_index_next;
    logic [6:0]  expected_reg_reg, expected_reg_next;
    logic [7:0]  running_crc_reg, running_crc_next;
    logic [15:0] tally_reg, tally_next;
    logic        echo_flag_reg, echo_flag_next;
    logic [7:0]  reply_bytes_reg [7];

    logic        accept;
    logic        store_byte;
    logic [3:0]  echo_dec;
    logic [15:0] tally_inc;
    logic [1:0]  reply_status;
    logic [31:0] reply_data;

    assign cmd.ready = !q_full;
    assign accept    = cmd.valid && cmd.ready;
    assign tally_inc = (tally_reg == 16'hFFFF) ? tally_reg : tally_reg + 16'd1;
    assign echo_dec  = (echo_left_reg != 4'd0) ? echo_left_reg - 4'd1 : echo_left_reg;
    assign reply_data = {reply_bytes_reg[3], reply_bytes_reg[4],
                         reply_bytes_reg[5], reply_bytes_reg[6]};

    // Header check comes before the CRC check.
    always_comb
    begin
        if (reply_bytes_reg[0] != sude_pkg::SYNC_BYTE ||
            reply_bytes_reg[1] != sude_pkg::MASTER_ADDR ||
            reply_bytes_reg[2] != {1'b0, expected_reg_reg})
        begin
            reply_status = sude_pkg::ST_BAD_HDR;
        end
        else if (running_crc_reg != cmd.rx_byte)
        begin
            reply_status = sude_pkg::ST_CRC_FAIL;
        end
        else
        begin
            reply_status = sude_pkg::ST_OK;
        end
    end

    // Next-state logic and job generation.
    always_comb
    begin
        phase_next        = phase_reg;
        echo_left_next    = echo_left_reg;
        reply_index_next  = reply_index_reg;
        expected_reg_next = expected_reg_reg;
        running_crc_next  = running_crc_reg;
        tally_next        = tally_reg;
        echo_flag_next    = echo_flag_reg;
        store_byte        = 1'b0;
        q_in              = '0;
        q_in.job.kind     = sude_pkg::JOB_REPLY;

        if (accept)
        begin
            case (cmd.opcode)
                sude_pkg::OP_WRITE, sude_pkg::OP_READ:
                begin
                    echo_flag_next   = 1'b0;
                    reply_index_next = 3'd0;
                    running_crc_next = 8'd0;
                    q_in.push        = 1'b1;
                    q_in.job.node    = cmd.node;
                    q_in.job.reg_addr = cmd.reg_req;
                    q_in.job.value   = cmd.value;
                    q_in.job.error_count = tally_reg;
                    q_in.job.echo    = 1'b0;
                    if (cmd.opcode == sude_pkg::OP_WRITE)
                    begin
                        echo_left_next = sude_pkg::WRITE_LEN;
                        phase_next     = PH_ECHO_WR;
                        q_in.job.kind  = sude_pkg::JOB_WRITE;
                    end
                    else
                    begin
                        echo_left_next    = sude_pkg::READ_LEN;
                        expected_reg_next = cmd.reg_req;
                        phase_next        = PH_ECHO_RD;
                        q_in.job.kind     = sude_pkg::JOB_READ;
                    end
                end
                sude_pkg::OP_RX:
                begin
                    if (phase_reg inside {PH_ECHO_WR, PH_ECHO_RD})
                    begin
                        echo_left_next = echo_dec;
                        if (echo_dec == 4'd0)
                        begin
                            echo_flag_next   = 1'b1;
                            phase_next       = (phase_reg == PH_ECHO_WR) ? PH_IDLE : PH_REPLY;
                            reply_index_next = 3'd0;
                            running_crc_next = 8'd0;
                        end
                    end
                    else if (phase_reg == PH_REPLY)
                    begin
                        if (reply_index_reg != 3'd7)
                        begin
                            store_byte       = 1'b1;
                            running_crc_next = sude_pkg::crc_feed(running_crc_reg, cmd.rx_byte);
                            reply_index_next = reply_index_reg + 3'd1;
                        end
                        else
                        begin
                            if (reply_status != sude_pkg::ST_OK)
                            begin
                                tally_next = tally_inc;
                            end
                            phase_next       = PH_IDLE;
                            reply_index_next = 3'd0;
                            q_in.push        = 1'b1;
                            q_in.job.status  = reply_status;
                            q_in.job.value   = (reply_status == sude_pkg::ST_OK) ?
                                               reply_data : 32'd0;
                            q_in.job.error_count = (reply_status == sude_pkg::ST_OK) ?
                                                   tally_reg : tally_inc;
                            q_in.job.echo    = echo_flag_reg;
                        end
                    end
                end
                default:
                begin
                    // Timeout tick ends whichever wait is in progress.
                    case (phase_reg)
                        PH_ECHO_WR:
                        begin
                            echo_flag_next = 1'b0;
                            echo_left_next = 4'd0;
                            phase_next     = PH_IDLE;
                        end
                        PH_ECHO_RD:
                        begin
                            echo_flag_next   = 1'b0;
                            echo_left_next   = 4'd0;
                            phase_next       = PH_REPLY;
                            reply_index_next = 3'd0;
                            running_crc_next = 8'd0;
                        end
                        PH_REPLY:
                        begin
                            tally_next       = tally_inc;
                            phase_next       = PH_IDLE;
                            reply_index_next = 3'd0;
                            q_in.push        = 1'b1;
                            q_in.job.status  = sude_pkg::ST_TIMEOUT;
                            q_in.job.error_count = tally_inc;
                            q_in.job.echo    = echo_flag_reg;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            endcase
        end
    end

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_IDLE;
            echo_left_reg    <= 4'd0;
            reply_index_reg  <= 3'd0;
            expected_reg_reg <= 7'd0;
            running_crc_reg  <= 8'd0;
            tally_reg        <= 16'd0;
            echo_flag_reg    <= 1'b0;
        end
        else
        begin
            phase_reg        <= phase_next;
            echo_left_reg    <= echo_left_next;
            reply_index_reg  <= reply_index_next;
            expected_reg_reg <= expected_reg_next;
            running_crc_reg  <= running_crc_next;
            tally_reg        <= tally_next;
            echo_flag_reg    <= echo_flag_next;
        end
    end

    // Reply byte store.
    always_ff @(posedge clk)
    begin
        if (store_byte)
        begin
            reply_bytes_reg[reply_index_reg] <= cmd.rx_byte;
        end
    end

`ifndef ASSERT_OFF
    a_tally_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        tally_reg >= $past(tally_reg))
        else $error("error counter went backwards");

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_in.push |-> !q_full)
        else $error("job pushed into a full queue");
`endif

endmodule

`default_nettype wire

/* hdl/sude_queue.sv */
`default_nettype none

// Small FIFO of jobs between the front and the back.
module sude_queue #(
    parameter int DEPTH = 2
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  sude_pkg::job_push_t q_in,
    output logic                full,
    output sude_pkg::job_t      head,
    output logic                head_valid,
    input  wire logic           pop
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    sude_pkg::job_t   entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = entry_reg[rd_ptr_reg];
    assign do_push    = q_in.push && !full;
    assign do_pop     = pop && head_valid;

    // Pointer and occupancy update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= q_in.job;
        end
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue occupancy beyond depth");
`endif

endmodule

`default_nettype wire

/* hdl/sude_back.sv */
`default_nettype none

// Datagram serializer: turns the job at the queue head into output words,
// one byte per cycle unless rsp stalls, with the CRC built up as the bytes go out.
module sude_back (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  sude_pkg::job_t head,
    input  wire logic      head_valid,
    output logic           pop,
    sude_rsp_if.source     rsp
);

    logic [2:0]  idx_reg, idx_next;
    logic [7:0]  crc_reg, crc_next;
    logic        valid_reg, valid_next;

    logic [7:0]  tx_byte_reg;
    logic        tx_valid_reg;
    logic        last_reg;
    logic        reply_valid_reg;
    logic [1:0]  status_reg;
    logic [31:0] read_value_reg;
    logic [15:0] error_count_reg;
    logic        echo_seen_reg;

    logic        load;
    logic        is_write;
    logic        is_reply;
    logic        is_last;
    logic [2:0]  last_idx;
    logic [7:0]  byte_val;

    assign load     = head_valid && (!valid_reg || rsp.ready);
    assign is_write = (head.kind == sude_pkg::JOB_WRITE);
    assign is_reply = (head.kind == sude_pkg::JOB_REPLY);
    assign last_idx = is_write ? 3'(sude_pkg::WRITE_LEN - 4'd1) :
                                 3'(sude_pkg::READ_LEN - 4'd1);
    assign is_last  = (idx_reg == last_idx);
    assign pop      = load && (is_reply || is_last);

    // Byte at the current datagram position.
    always_comb
    begin
        case (idx_reg)
            3'd0:    byte_val = sude_pkg::SYNC_BYTE;
            3'd1:    byte_val = head.node;
            3'd2:    byte_val = is_write ? ({1'b0, head.reg_addr} | sude_pkg::WRITE_FLAG) :
                                           {1'b0, head.reg_addr};
            3'd3:    byte_val = is_write ? head.value[31:24] : crc_reg;
            3'd4:    byte_val = head.value[23:16];
            3'd5:    byte_val = head.value[15:8];
            3'd6:    byte_val = head.value[7:0];
            default: byte_val = crc_reg;
        endcase
    end

    // Sequencer position, running CRC and output valid.
    always_comb
    begin
        idx_next   = idx_reg;
        crc_next   = crc_reg;
        valid_next = valid_reg;
        if (rsp.ready)
        begin
            valid_next = 1'b0;
        end
        if (load)
        begin
            valid_next = 1'b1;
            if (!is_reply)
            begin
                if (is_last)
                begin
                    idx_next = 3'd0;
                    crc_next = 8'd0;
                end
                else
                begin
                    idx_next = idx_reg + 3'd1;
                    crc_next = sude_pkg::crc_feed(crc_reg, byte_val);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= 3'd0;
            crc_reg   <= 8'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            crc_reg   <= crc_next;
            valid_reg <= valid_next;
        end
    end

    // Output word register.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            error_count_reg <= head.error_count;
            echo_seen_reg   <= head.echo;
            if (is_reply)
            begin
                tx_byte_reg     <= 8'd0;
                tx_valid_reg    <= 1'b0;
                last_reg        <= 1'b0;
                reply_valid_reg <= 1'b1;
                status_reg      <= head.status;
                read_value_reg  <= head.value;
            end
            else
            begin
                tx_byte_reg     <= byte_val;
                tx_valid_reg    <= 1'b1;
                last_reg        <= is_last;
                reply_valid_reg <= 1'b0;
                status_reg      <= sude_pkg::ST_OK;
                read_value_reg  <= 32'd0;
            end
        end
    end

    assign rsp.valid       = valid_reg;
    assign rsp.tx_byte     = tx_byte_reg;
    assign rsp.tx_valid    = tx_valid_reg;
    assign rsp.last        = last_reg;
    assign rsp.reply_valid = reply_valid_reg;
    assign rsp.status      = status_reg;
    assign rsp.read_value  = read_value_reg;
    assign rsp.error_count = error_count_reg;
    assign rsp.echo_seen   = echo_seen_reg;

`ifndef ASSERT_OFF
    a_mid_datagram_head: assert property (@(posedge clk) disable iff (!rst_n)
        (idx_reg != 3'd0) |-> (head_valid && !is_reply))
        else $error("datagram in progress without a transmit job at the head");

    a_pop_on_load: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> valid_reg)
        else $error("job retired without an output word");
`endif

endmodule

`default_nettype wire
